// File: design/arq_window_timer_event_picker_defines.svh
// Assertion macros shared by the checker of the ARQ window timer event picker.
`ifndef ARQ_WINDOW_TIMER_EVENT_PICKER_DEFINES_SVH
`define ARQ_WINDOW_TIMER_EVENT_PICKER_DEFINES_SVH

// same-cycle implication under active-low reset
`define AWTEP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("awtep: same-cycle check failed");

// next-cycle implication under active-low reset
`define AWTEP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("awtep: next-cycle check failed");

`endif

// File: design/awtep_pkg.sv
// Shared constants, codes and request/response types of the ARQ window timer event picker.
package awtep_pkg;

  localparam int unsigned WindowSlots = 8;
  localparam int unsigned SeqMax      = 15;
  localparam int unsigned SlotW       = (WindowSlots > 1) ? $clog2(WindowSlots) : 1;
  localparam int unsigned TickW       = 32;
  localparam int unsigned SeqInW      = 4;
  localparam int unsigned SeqW        = 5;
  localparam int unsigned SkewW       = 8;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned EvW         = 3;
  localparam int unsigned ClsW        = 2;
  localparam int unsigned InDataW     = 40;
  localparam int unsigned OutDataW    = 8;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;

  localparam logic [SeqW-1:0]  SeqNone        = SeqW'(SeqMax + 1);
  localparam logic [TickW-1:0] TimeoutReset   = TickW'(1000);
  localparam logic [SeqW-1:0]  InitSeqReset   = SeqW'(15);

  typedef enum logic [CmdW-1:0] {
    CMD_PICK      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_ACK_START = 3'd3,
    CMD_ACK_STOP  = 3'd4,
    CMD_RECORD    = 3'd5
  } awtep_cmd_e;

  typedef enum logic [EvW-1:0] {
    EV_NONE        = 3'd0,
    EV_ACK_TIMEOUT = 3'd1,
    EV_FRAME       = 3'd2,
    EV_CKSUM       = 3'd3,
    EV_SEND        = 3'd4,
    EV_TIMEOUT     = 3'd5
  } awtep_ev_e;

  typedef enum logic [ClsW-1:0] {
    CLS_DATA_GOOD = 2'd0,
    CLS_DATA_BAD  = 2'd1,
    CLS_ACK_NAK   = 2'd2,
    CLS_OTHER     = 2'd3
  } awtep_cls_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_SEND_EN  = 2'd1,
    REG_INIT_SEQ = 2'd2
  } awtep_reg_e;

  typedef enum logic [1:0] {
    OP_SET_DL  = 2'd0,
    OP_SET_SEQ = 2'd1,
    OP_MATCH   = 2'd2
  } awtep_op_e;

  typedef struct packed {
    logic              valid;
    awtep_op_e         op;
    logic [SlotW-1:0]  slot;
    logic [TickW-1:0]  deadline;
    logic [SeqInW-1:0] seq;
  } awtep_req_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [SeqW-1:0] seq;
  } awtep_rsp_t;

endpackage

// File: design/awtep_slot_bank.sv
// Slot deadline and sequence bank with a shared comparator that walks one slot per cycle.
module awtep_slot_bank (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  awtep_pkg::awtep_req_t          req_i,
  output awtep_pkg::awtep_rsp_t          rsp_o,
  output logic [awtep_pkg::TickW-1:0]    earliest_o
);
  import awtep_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MATCH,
    B_RESCAN
  } state_e;

  state_e            state_q;
  logic [TickW-1:0]  dl_q [WindowSlots];
  logic [SeqW-1:0]   sq_q [WindowSlots];
  logic [SlotW-1:0]  idx_q;
  logic [TickW-1:0]  best_q;
  logic [TickW-1:0]  earliest_q;
  awtep_rsp_t        rsp_q;

  logic [TickW-1:0]  cur_dl;
  logic              hit;
  logic              better;
  logic [TickW-1:0]  best_d;
  logic              last;

  assign cur_dl = dl_q[idx_q];
  assign hit    = (cur_dl == earliest_q);
  assign better = (cur_dl != '0) && (cur_dl < best_q);
  assign best_d = better ? cur_dl : best_q;
  assign last   = (idx_q == SlotW'(WindowSlots - 1));

  assign rsp_o      = rsp_q;
  assign earliest_o = earliest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      idx_q      <= '0;
      best_q     <= '1;
      earliest_q <= '1;
      rsp_q      <= '0;
      for (int i = 0; i < WindowSlots; i++) begin
        dl_q[i] <= '0;
        sq_q[i] <= SeqNone;
      end
    end else begin
      rsp_q.done <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (req_i.valid) begin
            rsp_q.found <= 1'b0;
            case (req_i.op)
              OP_SET_DL: begin
                dl_q[req_i.slot] <= req_i.deadline;
                idx_q            <= '0;
                best_q           <= '1;
                state_q          <= B_RESCAN;
              end
              OP_SET_SEQ: begin
                sq_q[req_i.slot] <= SeqW'(req_i.seq);
                rsp_q.done       <= 1'b1;
              end
              OP_MATCH: begin
                idx_q   <= '0;
                state_q <= B_MATCH;
              end
              default: begin
                rsp_q.done <= 1'b1;
              end
            endcase
          end
        end
        B_MATCH: begin
          if (hit) begin
            dl_q[idx_q] <= '0;
            rsp_q.found <= 1'b1;
            rsp_q.seq   <= sq_q[idx_q];
            idx_q       <= '0;
            best_q      <= '1;
            state_q     <= B_RESCAN;
          end else if (last) begin
            rsp_q.done <= 1'b1;
            state_q    <= B_IDLE;
          end else begin
            idx_q <= idx_q + SlotW'(1);
          end
        end
        B_RESCAN: begin
          best_q <= best_d;
          if (last) begin
            earliest_q <= best_d;
            rsp_q.done <= 1'b1;
            state_q    <= B_IDLE;
          end else begin
            idx_q <= idx_q + SlotW'(1);
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/arq_window_timer_event_picker.sv
// Top level of the ARQ window timer event picker: command sequencer, timers and stream ports.
// One transfer in gives one transfer out. The block is ready only between commands. Ack
// timer commands, plain picks and unknown commands go from the execute state straight to
// the done state, where the result register is loaded; record, slot start and slot stop
// wait for the slot bank. Start and stop wait while the slot bank walks the window one slot
// per cycle through its single comparator to refresh the earliest deadline. A pick that
// reaches the earliest deadline walks the window for the match and, on a hit, again for the
// refresh. The next command is taken while a result still waits in the output register; a
// result held by the sink stalls the following one in its last cycle. Configuration writes
// are registered directly and are meant for idle periods.
module arq_window_timer_event_picker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // now_tick [31:0], seq_num [35:32], frame_ready [36], frame_class [38:37], zero [39]
  input  logic [awtep_pkg::InDataW-1:0]     s_axis_tdata,
  // cmd [2:0]
  input  logic [awtep_pkg::CmdW-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // timed_out_seq [4:0], frame_consumed [5], zero [7:6]
  output logic [awtep_pkg::OutDataW-1:0]    m_axis_tdata,
  // event_res [2:0]
  output logic [awtep_pkg::EvW-1:0]         m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [awtep_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [awtep_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import awtep_pkg::*;

  typedef enum logic [1:0] {
    T_IDLE,
    T_EXEC,
    T_WAIT,
    T_DONE
  } state_e;

  state_e              state_q;
  awtep_cmd_e          cmd_q;
  logic [TickW-1:0]    now_q;
  logic [SeqInW-1:0]   seq_q;
  logic                rdy_q;
  awtep_cls_e          cls_q;
  logic [TickW-1:0]    timeout_q;
  logic                send_en_q;
  logic [TickW-1:0]    ack_q;
  logic [SkewW-1:0]    skew_q;
  logic [SeqW-1:0]     lto_q;
  awtep_ev_e           ev_q;
  logic                taken_q;
  awtep_req_t          req_q;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic [EvW-1:0]      m_user_q;

  awtep_rsp_t          rsp;
  logic [TickW-1:0]    earliest;
  logic [TickW-1:0]    start_dl;
  logic [TickW-1:0]    ack_dl;
  logic [SlotW-1:0]    slot;

  assign start_dl = now_q + timeout_q + TickW'(skew_q);
  assign ack_dl   = now_q + (timeout_q >> 1);
  assign slot     = SlotW'(seq_q % WindowSlots);

  assign s_axis_tready = (state_q == T_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  awtep_slot_bank u_slot_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_q),
    .rsp_o      (rsp),
    .earliest_o (earliest)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      cmd_q     <= CMD_PICK;
      now_q     <= '0;
      seq_q     <= '0;
      rdy_q     <= 1'b0;
      cls_q     <= CLS_DATA_GOOD;
      timeout_q <= TimeoutReset;
      send_en_q <= 1'b0;
      ack_q     <= '0;
      skew_q    <= '0;
      lto_q     <= InitSeqReset;
      ev_q      <= EV_NONE;
      taken_q   <= 1'b0;
      req_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      req_q.valid <= 1'b0;
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (awtep_reg_e'(cfg_idx_i))
          REG_TIMEOUT:  timeout_q <= cfg_wdata_i[TickW-1:0];
          REG_SEND_EN:  send_en_q <= cfg_wdata_i[0];
          REG_INIT_SEQ: lto_q     <= SeqW'(cfg_wdata_i[SeqInW-1:0]);
          default: ;
        endcase
      end
      case (state_q)
        T_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q   <= awtep_cmd_e'(s_axis_tuser);
            now_q   <= s_axis_tdata[31:0];
            seq_q   <= s_axis_tdata[35:32];
            rdy_q   <= s_axis_tdata[36];
            cls_q   <= awtep_cls_e'(s_axis_tdata[38:37]);
            ev_q    <= EV_NONE;
            taken_q <= 1'b0;
            state_q <= T_EXEC;
          end
        end
        T_EXEC: begin
          state_q <= T_DONE;
          case (cmd_q)
            CMD_PICK: begin
              skew_q <= '0;
              if ((ack_q != '0) && (now_q >= ack_q)) begin
                ack_q <= '0;
                ev_q  <= EV_ACK_TIMEOUT;
              end else if (rdy_q) begin
                taken_q <= 1'b1;
                case (cls_q)
                  CLS_DATA_GOOD, CLS_ACK_NAK: ev_q <= EV_FRAME;
                  CLS_DATA_BAD:               ev_q <= EV_CKSUM;
                  default:                    ev_q <= EV_NONE;
                endcase
              end else if (send_en_q) begin
                ev_q <= EV_SEND;
              end else if ((earliest != '0) && (now_q >= earliest)) begin
                req_q.valid <= 1'b1;
                req_q.op    <= OP_MATCH;
                state_q     <= T_WAIT;
              end
            end
            CMD_START: begin
              skew_q         <= skew_q + SkewW'(1);
              req_q.valid    <= 1'b1;
              req_q.op       <= OP_SET_DL;
              req_q.slot     <= slot;
              req_q.deadline <= start_dl;
              state_q        <= T_WAIT;
            end
            CMD_STOP: begin
              req_q.valid    <= 1'b1;
              req_q.op       <= OP_SET_DL;
              req_q.slot     <= slot;
              req_q.deadline <= '0;
              state_q        <= T_WAIT;
            end
            CMD_ACK_START: begin
              ack_q  <= ack_dl;
              skew_q <= skew_q + SkewW'(1);
            end
            CMD_ACK_STOP: begin
              ack_q <= '0;
            end
            CMD_RECORD: begin
              req_q.valid <= 1'b1;
              req_q.op    <= OP_SET_SEQ;
              req_q.slot  <= slot;
              req_q.seq   <= seq_q;
              state_q     <= T_WAIT;
            end
            default: ;
          endcase
        end
        T_WAIT: begin
          if (rsp.done) begin
            if (rsp.found) begin
              lto_q <= rsp.seq;
              ev_q  <= EV_TIMEOUT;
            end
            state_q <= T_DONE;
          end
        end
        T_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_user_q  <= ev_q;
            m_data_q  <= {2'b00, taken_q, lto_q};
            state_q   <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/awtep_checker.sv
// Port-level checker of the ARQ window timer event picker and its bind.
`include "arq_window_timer_event_picker_defines.svh"

module awtep_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [awtep_pkg::OutDataW-1:0]    m_axis_tdata,
  input logic [awtep_pkg::EvW-1:0]         m_axis_tuser
);
  import awtep_pkg::*;

  logic in_xfer;
  logic consumed;
  logic out_stall;
  logic kind_ok;
  logic pad_ok;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign consumed  = m_axis_tdata[5];
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign kind_ok   = (m_axis_tuser == EV_FRAME) || (m_axis_tuser == EV_CKSUM) ||
                     (m_axis_tuser == EV_NONE);
  assign pad_ok    = (m_axis_tdata[7:6] == 2'b00);

  `AWTEP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_xfer, !s_axis_tready)
  `AWTEP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid)
  `AWTEP_ASSERT_NOW(a_consume_kind, clk_i, rst_ni, m_axis_tvalid && consumed, kind_ok)
  `AWTEP_ASSERT_NOW(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, pad_ok)

endmodule

bind arq_window_timer_event_picker awtep_checker u_awtep_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the ARQ window timer event picker: directed and random command streams.
`timescale 1ns / 100ps

module testbench;
  import awtep_pkg::*;

  localparam logic [CmdW-1:0]    CmdSpareA = 3'd6;
  localparam logic [CmdW-1:0]    CmdSpareB = 3'd7;
  localparam logic [CfgIdxW-1:0] RegSpare  = 2'd3;

  typedef struct packed {
    awtep_ev_e       ev;
    logic [SeqW-1:0] seq;
    logic            taken;
  } event_rec_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [CmdW-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [EvW-1:0]      m_axis_tuser;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  logic [TickW-1:0] tmr_deadline [WindowSlots];
  logic [SeqW-1:0]  tmr_seq [WindowSlots];
  logic [TickW-1:0] tmr_earliest;
  logic [TickW-1:0] tmr_ack_due;
  logic [SkewW-1:0] tmr_skew;
  logic [SeqW-1:0]  tmr_last_seq;
  logic [TickW-1:0] cfg_timeout;
  logic             cfg_send_en;

  event_rec_t  expected_events[$];
  int unsigned mismatches;
  int unsigned stall_left;
  bit          calm;

  arq_window_timer_event_picker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void refresh_earliest();
    logic [TickW-1:0] best;
    best = '1;
    for (int i = 0; i < WindowSlots; i++) begin
      if (tmr_deadline[i] != '0 && tmr_deadline[i] < best) best = tmr_deadline[i];
    end
    tmr_earliest = best;
  endfunction

  function automatic event_rec_t predict_event(input logic [CmdW-1:0] cmd,
      input logic [TickW-1:0] now, input logic [SeqInW-1:0] seq, input logic rdy,
      input logic [ClsW-1:0] cls);
    event_rec_t rec;
    int unsigned slot;
    bit hit;
    rec.ev = EV_NONE;
    rec.taken = 1'b0;
    slot = seq % WindowSlots;
    hit = 1'b0;
    case (cmd)
      CMD_PICK: begin
        tmr_skew = '0;
        if (tmr_ack_due != '0 && now >= tmr_ack_due) begin
          tmr_ack_due = '0;
          rec.ev = EV_ACK_TIMEOUT;
        end else if (rdy) begin
          rec.taken = 1'b1;
          if (cls == CLS_DATA_BAD) rec.ev = EV_CKSUM;
          else if (cls != CLS_OTHER) rec.ev = EV_FRAME;
        end else if (cfg_send_en) begin
          rec.ev = EV_SEND;
        end else if (tmr_earliest != '0 && now >= tmr_earliest) begin
          for (int i = 0; i < WindowSlots; i++) begin
            if (!hit && tmr_deadline[i] == tmr_earliest) begin
              hit = 1'b1;
              tmr_deadline[i] = '0;
              tmr_last_seq = tmr_seq[i];
              rec.ev = EV_TIMEOUT;
            end
          end
          if (hit) refresh_earliest();
        end
      end
      CMD_START: begin
        tmr_deadline[slot] = now + cfg_timeout + TickW'(tmr_skew);
        tmr_skew = tmr_skew + 1'b1;
        refresh_earliest();
      end
      CMD_STOP: begin
        tmr_deadline[slot] = '0;
        refresh_earliest();
      end
      CMD_ACK_START: begin
        tmr_ack_due = now + (cfg_timeout >> 1);
        tmr_skew = tmr_skew + 1'b1;
      end
      CMD_ACK_STOP: tmr_ack_due = '0;
      CMD_RECORD: tmr_seq[slot] = SeqW'(seq);
      default: ;
    endcase
    rec.seq = tmr_last_seq;
    return rec;
  endfunction

  task automatic send_cmd(input logic [CmdW-1:0] cmd, input logic [TickW-1:0] now,
      input logic [SeqInW-1:0] seq, input logic rdy, input logic [ClsW-1:0] cls);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, cls, rdy, seq, now};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_events.push_back(predict_event(cmd, now, seq, rdy, cls));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_TIMEOUT:  cfg_timeout = data;
      REG_SEND_EN:  cfg_send_en = data[0];
      REG_INIT_SEQ: tmr_last_seq = SeqW'(data[3:0]);
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = idle_len();
    end
  end

  always @(posedge clk_i) begin
    event_rec_t rec;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        if (mismatches < 10) $display("unexpected transfer: ev=%0d seq=%0d taken=%0b",
                                      m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[5]);
        mismatches++;
      end else begin
        rec = expected_events.pop_front();
        if (m_axis_tuser !== rec.ev || m_axis_tdata[4:0] !== rec.seq ||
            m_axis_tdata[5] !== rec.taken) begin
          if (mismatches < 10)
            $display("mismatch: expected ev=%0d seq=%0d taken=%0b, got ev=%0d seq=%0d taken=%0b",
                     rec.ev, rec.seq, rec.taken,
                     m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[5]);
          mismatches++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_cmd(CMD_PICK, 32'd0, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'hffff_ffff, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CmdSpareA, 32'h1234_5678, 4'd9, 1'b1, CLS_DATA_BAD);
    send_cmd(CmdSpareB, 32'hffff_ffff, 4'd15, 1'b1, CLS_OTHER);
  endtask

  task automatic test_slot_timers();
    send_cmd(CMD_RECORD, 32'd0, 4'd15, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_RECORD, 32'd0, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_RECORD, 32'd0, 4'd8, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_START, 32'd0, 4'd15, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_START, 32'hffff_ffff, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_ACK_START, 32'd100, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd599, 4'd0, 1'b1, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd600, 4'd0, 1'b1, CLS_DATA_BAD);
    send_cmd(CMD_PICK, 32'd600, 4'd0, 1'b1, CLS_DATA_BAD);
    send_cmd(CMD_PICK, 32'd600, 4'd0, 1'b1, CLS_ACK_NAK);
    send_cmd(CMD_PICK, 32'd600, 4'd0, 1'b1, CLS_OTHER);
    send_cmd(CMD_PICK, 32'd999, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd1000, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd1000, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_START, 32'hffff_fc18, 4'd3, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_START, 32'd5, 4'd4, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_STOP, 32'd0, 4'd4, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_START, 32'd0, 4'd12, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_ACK_START, 32'd0, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_ACK_STOP, 32'd0, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd2000, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_START, 32'hffff_fc17, 4'd1, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'hffff_fffe, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'hffff_ffff, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'hffff_ffff, 4'd0, 1'b0, CLS_DATA_GOOD);
  endtask

  task automatic test_registers();
    wait_idle();
    write_reg(RegSpare, 32'hffff_ffff);
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_SEND_EN, 32'd1);
    write_reg(REG_INIT_SEQ, 32'd0);
    send_cmd(CMD_PICK, 32'd3, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_ACK_START, 32'd7, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd7, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_START, 32'd50, 4'd6, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd60, 4'd0, 1'b0, CLS_DATA_GOOD);
    wait_idle();
    write_reg(REG_TIMEOUT, 32'hffff_ffff);
    write_reg(REG_SEND_EN, 32'd0);
    write_reg(REG_INIT_SEQ, 32'd15);
    write_reg(RegSpare, 32'd0);
    send_cmd(CMD_ACK_START, 32'd10, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd10, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_START, 32'd10, 4'd2, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd70, 4'd0, 1'b0, CLS_DATA_GOOD);
    send_cmd(CMD_PICK, 32'd70, 4'd0, 1'b0, CLS_DATA_GOOD);
  endtask

  task automatic test_random_traffic();
    logic [TickW-1:0] tick;
    logic [TickW-1:0] now;
    logic [CmdW-1:0]  cmd;
    logic [SeqInW-1:0] seq;
    logic [ClsW-1:0]  cls;
    logic             rdy;
    logic [TickW-1:0] stride;
    int unsigned      r;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: write_reg(REG_TIMEOUT, 32'd40);
        1: write_reg(REG_TIMEOUT, 32'd0);
        2: write_reg(REG_TIMEOUT, 32'd1);
        3: write_reg(REG_TIMEOUT, 32'd300);
        4: write_reg(REG_TIMEOUT, 32'hffff_ffff);
        5: write_reg(REG_TIMEOUT, 32'h8000_0000);
        6: write_reg(REG_TIMEOUT, $urandom_range(2, 500));
        default: write_reg(REG_TIMEOUT, 32'd17);
      endcase
      write_reg(REG_SEND_EN, (ph == 3 || ph == 7) ? 32'd1 : 32'd0);
      write_reg(REG_INIT_SEQ, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd15 : $urandom_range(0, 15));
      if (ph == 5) write_reg(RegSpare, $urandom());
      stride = (cfg_timeout > 32'd1000) ? 32'd200 : (cfg_timeout >> 3) + 32'd2;
      tick = (ph == 7) ? 32'hffff_ff00 : $urandom_range(0, 1000);
      for (int n = 0; n < 250; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 4) == 0);
        r    = $urandom_range(0, 99);
        tick = tick + $urandom_range(0, stride);
        now  = tick + $urandom_range(0, 3);
        seq  = SeqInW'($urandom_range(0, 15));
        rdy  = ($urandom_range(0, 4) == 0);
        cls  = ClsW'($urandom_range(0, 3));
        if (r < 40) begin
          cmd = CMD_PICK;
        end else if (r < 60) begin
          cmd = CMD_START;
          if ($urandom_range(0, 1)) send_cmd(CMD_RECORD, now, seq, rdy, cls);
        end else if (r < 68) begin
          cmd = CMD_STOP;
        end else if (r < 80) begin
          cmd = CMD_RECORD;
        end else if (r < 88) begin
          cmd = CMD_ACK_START;
        end else if (r < 93) begin
          cmd = CMD_ACK_STOP;
        end else if (r < 96) begin
          cmd = $urandom_range(0, 1) ? CmdSpareA : CmdSpareB;
        end else begin
          cmd = CmdW'($urandom_range(0, 7));
          now = $urandom();
          rdy = ($urandom_range(0, 1) == 1);
        end
        send_cmd(cmd, now, seq, rdy, cls);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    mismatches    = 0;
    stall_left    = 0;
    calm          = 1'b0;
    for (int i = 0; i < WindowSlots; i++) begin
      tmr_deadline[i] = '0;
      tmr_seq[i]      = SeqNone;
    end
    tmr_earliest = '1;
    tmr_ack_due  = '0;
    tmr_skew     = '0;
    tmr_last_seq = InitSeqReset;
    cfg_timeout  = TimeoutReset;
    cfg_send_en  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_slot_timers();
    test_registers();
    test_random_traffic();
    wait_idle();

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/awtep_pkg.sv
design/awtep_slot_bank.sv
design/arq_window_timer_event_picker.sv
design/awtep_checker.sv
bench/testbench.sv
